>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BAMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BAMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/bams_pkg.sv
// ----------------------------------------------------------------------------
// bams_pkg
// Shared types and constants of the biquad magnitude-squared unit.
// ----------------------------------------------------------------------------
package bams_pkg;

  localparam int unsigned DW      = 32;   // register and field width
  localparam int unsigned NW      = 256;  // scaled numerator/denominator width
  localparam int unsigned QW      = 32;   // quotient width
  localparam int unsigned DIV_LAT = QW + 1;

  localparam int unsigned SETTLE_CYC = 40;
  localparam int unsigned SETTLE_W   = $clog2(SETTLE_CYC + 1);

  typedef enum logic [2:0] {
    FT_LOWPASS  = 3'd0,
    FT_HIGHPASS = 3'd1,
    FT_BANDPASS = 3'd2,
    FT_NOTCH    = 3'd3,
    FT_PEAK     = 3'd4,
    FT_TILT     = 3'd5
  } ftype_e;

  typedef enum logic [1:0] {
    REG_TYPE    = 2'd0,
    REG_CENTER  = 2'd1,
    REG_QUALITY = 2'd2,
    REG_GAIN    = 2'd3
  } reg_e;

  typedef struct packed {
    logic zero;
    logic ovf;
  } div_flags_t;

endpackage

>>> hdl/bams_mul.sv
// ----------------------------------------------------------------------------
// bams_mul
// Pipelined unsigned multiplier, one 32x32 partial product per stage.
// ----------------------------------------------------------------------------
module bams_mul #(
  parameter int unsigned WA = 32,
  parameter int unsigned WB = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  output logic [WA+WB-1:0] p_o
);

  localparam int unsigned NA  = (WA + 31) / 32;
  localparam int unsigned NB  = (WB + 31) / 32;
  localparam int unsigned NS  = NA * NB;
  localparam int unsigned WPA = 32 * NA;
  localparam int unsigned WPB = 32 * NB;
  localparam int unsigned WC  = WPA + WPB;

  logic [WPA-1:0] a_q   [NS];
  logic [WPB-1:0] b_q   [NS];
  logic [WC-1:0]  acc_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int unsigned I = s / NB;
    localparam int unsigned J = s % NB;
    logic [WPA-1:0] a_in;
    logic [WPB-1:0] b_in;
    logic [WC-1:0]  acc_in;
    logic [63:0]    pp;

    if (s == 0) begin : g_first
      assign a_in   = WPA'(a_i);
      assign b_in   = WPB'(b_i);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[s-1];
      assign b_in   = b_q[s-1];
      assign acc_in = acc_q[s-1];
    end

    assign pp = 64'(a_in[32*I +: 32]) * 64'(b_in[32*J +: 32]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[s]   <= a_in;
        b_q[s]   <= b_in;
        acc_q[s] <= acc_in + (WC'(pp) << (32 * (I + J)));
      end
    end
  end

  assign p_o = acc_q[NS-1][WA+WB-1:0];

endmodule

>>> hdl/bams_dly.sv
// ----------------------------------------------------------------------------
// bams_dly
// Enabled delay line for pipeline alignment.
// ----------------------------------------------------------------------------
module bams_dly #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  for (genvar s = 0; s < N; s++) begin : g_tap
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tap_q[s] <= (s == 0) ? d_i : tap_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

>>> hdl/bams_sqrt.sv
// ----------------------------------------------------------------------------
// bams_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module bams_sqrt #(
  parameter int unsigned WR = 28
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*WR-1:0] v_i,
  output logic [WR-1:0]   root_o
);

  logic [2*WR-1:0] v_q    [WR];
  logic [WR+1:0]   rem_q  [WR];
  logic [WR-1:0]   root_q [WR];

  for (genvar s = 0; s < WR; s++) begin : g_stage
    localparam int unsigned P = WR - 1 - s;
    logic [2*WR-1:0] v_in;
    logic [WR+1:0]   rem_in;
    logic [WR-1:0]   root_in;
    logic [WR+1:0]   rem_sh;
    logic [WR+1:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign v_in    = v_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    assign rem_sh = {rem_in[WR-1:0], v_in[2*P +: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s]    <= v_in;
        rem_q[s]  <= ge ? rem_sh - trial : rem_sh;
        root_q[s] <= {root_in[WR-2:0], ge};
      end
    end
  end

  assign root_o = root_q[WR-1];

endmodule

>>> hdl/bams_div.sv
// ----------------------------------------------------------------------------
// bams_div
// Range check and pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bams_div #(
  parameter int unsigned WN = 256,
  parameter int unsigned RF = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [WN-1:0]           num_i,
  input  logic [WN-1:0]           den_i,
  output logic [bams_pkg::QW-1:0] quo_o,
  output bams_pkg::div_flags_t    flags_o
);

  localparam int unsigned QW = bams_pkg::QW;
  localparam int unsigned WR = WN + QW;

  logic [WR-1:0]        rem_q [QW+1];
  logic [WN-1:0]        den_q [QW+1];
  logic [QW-1:0]        quo_q [QW+1];
  bams_pkg::div_flags_t fl_q  [QW+1];

  logic [WR-1:0] rem0;
  logic [WR-1:0] dtop;

  assign rem0 = WR'(num_i) << RF;
  assign dtop = WR'(den_i) << QW;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]     <= rem0;
      den_q[0]     <= den_i;
      quo_q[0]     <= '0;
      fl_q[0].zero <= (den_i == '0);
      fl_q[0].ovf  <= (den_i != '0) && (rem0 >= dtop);
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int unsigned K = QW - s;
    logic [WR-1:0] dk;
    logic          ge;
    logic [QW-1:0] qn;

    assign dk = WR'(den_q[s-1]) << K;
    assign ge = rem_q[s-1] >= dk;

    always_comb begin
      qn    = quo_q[s-1];
      qn[K] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? rem_q[s-1] - dk : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        quo_q[s] <= qn;
        fl_q[s]  <= fl_q[s-1];
      end
    end
  end

  assign quo_o   = quo_q[QW];
  assign flags_o = fl_q[QW];

endmodule

>>> hdl/biquad_analog_magnitude_squared_unit.sv
// ----------------------------------------------------------------------------
// biquad_analog_magnitude_squared_unit
// Squared magnitude of a second-order analog filter at one frequency point.
// ----------------------------------------------------------------------------
// Fully pipelined: one frequency word enters per cycle while in_ready_o is high
// and its result leaves through the output register; the latency does not depend
// on RESULT_FRAC_BITS. It is set by the multiplier chain, built from
// 32x32 partial-product stages (the widest, 96 by 184 bits, takes 18), and by
// the divider, which resolves one quotient bit per stage after a range check.
// The pipeline stalls only while the output register holds a word that is not
// taken, and the last stage is full. Coefficients are derived from the
// registers in free-running pipes (the gain square root takes 28 stages);
// after every configuration write in_ready_o is held low while they settle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_analog_magnitude_squared_unit #(
  parameter int unsigned RESULT_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] freq_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] mag_squared_o,
  output logic        saturated_o,
  output logic        zero_denominator_o
);

  localparam int unsigned DW   = bams_pkg::DW;
  localparam int unsigned NW   = bams_pkg::NW;
  localparam int unsigned W_X  = 64;
  localparam int unsigned W_A  = 28;
  localparam int unsigned W_AX = 92;
  localparam int unsigned W_CX = 128;
  localparam int unsigned W_D  = 92;
  localparam int unsigned W_D2 = 184;
  localparam int unsigned W_QM = 96;
  localparam int unsigned W_QP = 280;
  localparam int unsigned W_KM = 64;
  localparam int unsigned W_CK = 192;

  localparam int unsigned L_X  = ((DW + 31) / 32) * ((DW + 31) / 32);
  localparam int unsigned L_AX = ((W_A + 31) / 32) * ((W_X + 31) / 32);
  localparam int unsigned L_CX = ((W_X + 31) / 32) * ((W_X + 31) / 32);
  localparam int unsigned L_SQ = ((W_D + 31) / 32) * ((W_D + 31) / 32);
  localparam int unsigned L_QP = ((W_QM + 31) / 32) * ((W_D2 + 31) / 32);
  localparam int unsigned L_CK = ((W_CX + 31) / 32) * ((W_KM + 31) / 32);
  localparam int unsigned T_X  = L_X;
  localparam int unsigned T_AX = T_X + L_AX;
  localparam int unsigned T_SQ = T_AX + 1 + L_SQ;
  localparam int unsigned T_QP = T_SQ + L_QP;
  localparam int unsigned T_CK = T_X + L_CX + L_CK;
  localparam int unsigned D_CK = T_QP - T_CK;
  localparam int unsigned LAT  = T_QP + 1 + bams_pkg::DIV_LAT;

  typedef enum logic [1:0] {SH_0, SH_48, SH_72, SH_96} sh_e;
  typedef enum logic [1:0] {DN_C, DN_X, DN_CX, DN_TILT} dsel_e;

  typedef struct packed {
    logic [W_KM-1:0] km_n;
    sh_e             ks_n;
    logic [W_QM-1:0] qm_n;
    logic            qs_n;
    logic [W_KM-1:0] km_d;
    sh_e             ks_d;
    logic [W_QM-1:0] qm_d;
    logic            qs_d;
    dsel_e           dsel_n;
    logic            tilt_d;
  } coef_t;

  // configuration registers
  logic [2:0]  type_q;
  logic [31:0] center_q, quality_q, gain_q;
  logic [bams_pkg::SETTLE_W-1:0] settle_q;
  logic        cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q    <= bams_pkg::FT_LOWPASS;
      center_q  <= 32'd268435456;
      quality_q <= 32'd11863283;
      gain_q    <= 32'd16777216;
      settle_q  <= '0;
    end else begin
      if (cfg_acc) begin
        settle_q <= bams_pkg::SETTLE_W'(bams_pkg::SETTLE_CYC);
        unique case (cfg_index_i)
          bams_pkg::REG_TYPE:    type_q    <= cfg_data_i[2:0];
          bams_pkg::REG_CENTER:  center_q  <= cfg_data_i;
          bams_pkg::REG_QUALITY: quality_q <= cfg_data_i;
          bams_pkg::REG_GAIN:    gain_q    <= cfg_data_i;
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 1'b1;
      end
    end
  end

  // free-running coefficient pipes
  logic [63:0]     c_sq, q_sq, g_sq;
  logic [W_A-1:0]  a_rt;
  logic [W_AX-1:0] ac;
  logic [W_QM-1:0] qg;
  coef_t           coef_d, coef_q;

  bams_mul #(.WA(32), .WB(32)) u_mul_c (
    .clk_i, .en_i(1'b1), .a_i(center_q), .b_i(center_q), .p_o(c_sq));
  bams_mul #(.WA(32), .WB(32)) u_mul_q (
    .clk_i, .en_i(1'b1), .a_i(quality_q), .b_i(quality_q), .p_o(q_sq));
  bams_mul #(.WA(32), .WB(32)) u_mul_g (
    .clk_i, .en_i(1'b1), .a_i(gain_q), .b_i(gain_q), .p_o(g_sq));
  bams_sqrt #(.WR(W_A)) u_sqrt (
    .clk_i, .en_i(1'b1), .v_i({gain_q, 24'b0}), .root_o(a_rt));
  bams_mul #(.WA(W_A), .WB(64)) u_mul_ac (
    .clk_i, .en_i(1'b1), .a_i(a_rt), .b_i(c_sq), .p_o(ac));
  bams_mul #(.WA(64), .WB(32)) u_mul_qg (
    .clk_i, .en_i(1'b1), .a_i(q_sq), .b_i(gain_q), .p_o(qg));

  always_comb begin
    coef_d.km_n   = '0;
    coef_d.ks_n   = SH_0;
    coef_d.qm_n   = '0;
    coef_d.qs_n   = 1'b0;
    coef_d.km_d   = W_KM'(1);
    coef_d.ks_d   = SH_48;
    coef_d.qm_d   = W_QM'(q_sq);
    coef_d.qs_d   = 1'b0;
    coef_d.dsel_n = DN_CX;
    coef_d.tilt_d = 1'b0;
    unique case (type_q)
      bams_pkg::FT_LOWPASS: begin
        coef_d.qm_n   = W_QM'(q_sq);
        coef_d.dsel_n = DN_C;
      end
      bams_pkg::FT_HIGHPASS: begin
        coef_d.qm_n   = W_QM'(q_sq);
        coef_d.dsel_n = DN_X;
      end
      bams_pkg::FT_BANDPASS: begin
        coef_d.km_n = W_KM'(1);
        coef_d.ks_n = SH_48;
      end
      bams_pkg::FT_NOTCH: begin
        coef_d.qm_n = W_QM'(q_sq);
      end
      bams_pkg::FT_PEAK: begin
        coef_d.km_n = g_sq;
        coef_d.ks_n = SH_48;
        coef_d.qm_n = qg;
        coef_d.qs_n = 1'b1;
        coef_d.ks_d = SH_96;
        coef_d.qm_d = qg;
        coef_d.qs_d = 1'b1;
      end
      bams_pkg::FT_TILT: begin
        coef_d.km_n   = W_KM'(a_rt);
        coef_d.ks_n   = SH_72;
        coef_d.qm_n   = W_QM'(q_sq);
        coef_d.km_d   = W_KM'(a_rt);
        coef_d.ks_d   = SH_72;
        coef_d.dsel_n = DN_TILT;
        coef_d.tilt_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  // flow control
  logic           en, acc;
  logic [LAT-1:0] vld_q;
  logic           out_v_q;

  assign en         = !vld_q[LAT-1] || !out_v_q || out_ready_i;
  assign in_ready_o = en && (settle_q == '0);
  assign acc        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], acc};
    end
  end

  // item datapath
  logic [W_X-1:0]  x_sq, x_d;
  logic [W_AX-1:0] ax;
  logic [W_CX-1:0] cx;
  logic [W_D-1:0]  un, vn, ud, vd, dn_q, dd_q;
  logic [W_D2-1:0] dn2, dd2;
  logic [W_QP-1:0] qpn, qpd;
  logic [W_CK-1:0] ckn, ckd, ckn_d, ckd_d;
  logic [NW-1:0]   num_q, den_q;

  bams_mul #(.WA(32), .WB(32)) u_mul_x (
    .clk_i, .en_i(en), .a_i(freq_i), .b_i(freq_i), .p_o(x_sq));
  bams_mul #(.WA(W_A), .WB(W_X)) u_mul_ax (
    .clk_i, .en_i(en), .a_i(a_rt), .b_i(x_sq), .p_o(ax));
  bams_mul #(.WA(64), .WB(W_X)) u_mul_cx (
    .clk_i, .en_i(en), .a_i(c_sq), .b_i(x_sq), .p_o(cx));
  bams_dly #(.W(W_X), .N(L_AX)) u_dly_x (
    .clk_i, .en_i(en), .d_i(x_sq), .q_o(x_d));

  always_comb begin
    case (coef_q.dsel_n)
      DN_C:    begin un = W_D'(c_sq);            vn = '0;         end
      DN_X:    begin un = W_D'(x_d);             vn = '0;         end
      DN_CX:   begin un = W_D'(c_sq);            vn = W_D'(x_d);  end
      DN_TILT: begin un = W_D'({c_sq, 24'b0});   vn = ax;         end
      default: begin un = '0;                    vn = '0;         end
    endcase
    if (coef_q.tilt_d) begin
      ud = ac;
      vd = W_D'({x_d, 24'b0});
    end else begin
      ud = W_D'(c_sq);
      vd = W_D'(x_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_q <= (un >= vn) ? un - vn : vn - un;
      dd_q <= (ud >= vd) ? ud - vd : vd - ud;
    end
  end

  bams_mul #(.WA(W_D), .WB(W_D)) u_mul_dn2 (
    .clk_i, .en_i(en), .a_i(dn_q), .b_i(dn_q), .p_o(dn2));
  bams_mul #(.WA(W_D), .WB(W_D)) u_mul_dd2 (
    .clk_i, .en_i(en), .a_i(dd_q), .b_i(dd_q), .p_o(dd2));
  bams_mul #(.WA(W_QM), .WB(W_D2)) u_mul_qpn (
    .clk_i, .en_i(en), .a_i(coef_q.qm_n), .b_i(dn2), .p_o(qpn));
  bams_mul #(.WA(W_QM), .WB(W_D2)) u_mul_qpd (
    .clk_i, .en_i(en), .a_i(coef_q.qm_d), .b_i(dd2), .p_o(qpd));
  bams_mul #(.WA(W_CX), .WB(W_KM)) u_mul_ckn (
    .clk_i, .en_i(en), .a_i(cx), .b_i(coef_q.km_n), .p_o(ckn));
  bams_mul #(.WA(W_CX), .WB(W_KM)) u_mul_ckd (
    .clk_i, .en_i(en), .a_i(cx), .b_i(coef_q.km_d), .p_o(ckd));
  bams_dly #(.W(W_CK), .N(D_CK)) u_dly_ckn (
    .clk_i, .en_i(en), .d_i(ckn), .q_o(ckn_d));
  bams_dly #(.W(W_CK), .N(D_CK)) u_dly_ckd (
    .clk_i, .en_i(en), .d_i(ckd), .q_o(ckd_d));

  function automatic logic [NW-1:0] shift_k(input logic [W_CK-1:0] v, input sh_e s);
    logic [NW-1:0] e;
    e = NW'(v);
    case (s)
      SH_0:    shift_k = e;
      SH_48:   shift_k = e << 48;
      SH_72:   shift_k = e << 72;
      SH_96:   shift_k = e << 96;
      default: shift_k = e;
    endcase
  endfunction

  function automatic logic [NW-1:0] shift_q(input logic [W_QP-1:0] v, input logic s24);
    logic [NW-1:0] e;
    e = NW'(v);
    shift_q = s24 ? e << 24 : e;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= shift_k(ckn_d, coef_q.ks_n) + shift_q(qpn, coef_q.qs_n);
      den_q <= shift_k(ckd_d, coef_q.ks_d) + shift_q(qpd, coef_q.qs_d);
    end
  end

  logic [bams_pkg::QW-1:0] quo;
  bams_pkg::div_flags_t    flags;

  bams_div #(.WN(NW), .RF(RESULT_FRAC_BITS)) u_div (
    .clk_i, .en_i(en), .num_i(num_q), .den_i(den_q), .quo_o(quo), .flags_o(flags));

  // result select and output register
  logic        type_ok;
  logic [31:0] res_mag;
  logic        res_sat, res_zd;
  logic [31:0] mag_q;
  logic        sat_q, zd_q;

  always_comb begin
    unique case (type_q) inside
      bams_pkg::FT_LOWPASS, bams_pkg::FT_HIGHPASS, bams_pkg::FT_BANDPASS,
      bams_pkg::FT_NOTCH, bams_pkg::FT_PEAK, bams_pkg::FT_TILT: type_ok = 1'b1;
      default: type_ok = 1'b0;
    endcase
    res_mag = quo;
    res_sat = 1'b0;
    res_zd  = 1'b0;
    if (!type_ok) begin
      res_mag = '0;
    end else if (flags.zero) begin
      res_mag = '1;
      res_zd  = 1'b1;
    end else if (flags.ovf) begin
      res_mag = '1;
      res_sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      mag_q <= res_mag;
      sat_q <= res_sat;
      zd_q  <= res_zd;
    end
  end

  assign out_valid_o        = out_v_q;
  assign mag_squared_o      = mag_q;
  assign saturated_o        = sat_q;
  assign zero_denominator_o = zd_q;

  `BAMS_ASSERT_NXT(a_cfg_blocks_input, cfg_acc, !in_ready_o)
  `BAMS_ASSERT_NXT(a_stall_keeps_last, vld_q[LAT-1] && !en, vld_q[LAT-1])
  `BAMS_ASSERT_IMP(a_flags_exclusive, out_valid_o, !(saturated_o && zero_denominator_o))

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the biquad magnitude-squared unit: random
// register settings and frequency sweeps, results predicted with exact wide
// integer arithmetic and compared in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASES      = 40;
  localparam int unsigned PER_PHASE   = 26;

  typedef logic [383:0] wide_t;

  typedef struct packed {
    logic [31:0] mag;
    logic        sat;
    logic        zden;
  } mag_word_t;

  class mag_scoreboard;
    logic [2:0]  ftype;
    logic [31:0] w0;
    logic [31:0] qual;
    logic [31:0] gain;
    mag_word_t   expected_q[$];
    int          errors;
    int          checked;
    int          n_sat;
    int          n_zden;

    function void set_reg(bams_pkg::reg_e idx, logic [31:0] d);
      case (idx)
        bams_pkg::REG_TYPE:    ftype = d[2:0];
        bams_pkg::REG_CENTER:  w0 = d;
        bams_pkg::REG_QUALITY: qual = d;
        bams_pkg::REG_GAIN:    gain = d;
        default: ;
      endcase
    endfunction

    function logic [63:0] gain_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function wide_t absdiff(wide_t a, wide_t b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function mag_word_t magnitude(logic [31:0] f);
      wide_t bx, bc, bq, cx, d2, num, den, gb, ab, acx, u1, u2, scaled;
      mag_word_t r;
      bx = wide_t'(f) * wide_t'(f);
      bc = wide_t'(w0) * wide_t'(w0);
      bq = wide_t'(qual) * wide_t'(qual);
      cx = bc * bx;
      d2 = absdiff(bc, bx);
      d2 = d2 * d2;
      den = (cx << 48) + bq * d2;
      r = '0;
      case (ftype)
        bams_pkg::FT_LOWPASS:  num = bq * (bc * bc);
        bams_pkg::FT_HIGHPASS: num = bq * (bx * bx);
        bams_pkg::FT_BANDPASS: num = cx << 48;
        bams_pkg::FT_NOTCH:    num = bq * d2;
        bams_pkg::FT_PEAK: begin
          gb = wide_t'(gain);
          d2 = ((bq * gb) << 24) * d2;
          num = ((cx * (gb * gb)) << 48) + d2;
          den = (cx << 96) + d2;
        end
        bams_pkg::FT_TILT: begin
          ab = wide_t'(gain_root({gain, 24'd0}));
          acx = (ab * cx) << 72;
          u1 = absdiff(bc << 24, ab * bx);
          u2 = absdiff(ab * bc, bx << 24);
          num = acx + bq * (u1 * u1);
          den = acx + bq * (u2 * u2);
        end
        default: return r;
      endcase
      if (den == 0) begin
        r.mag = '1;
        r.zden = 1'b1;
        return r;
      end
      scaled = num << 16;
      if (scaled >= (den << 32)) begin
        r.mag = '1;
        r.sat = 1'b1;
        return r;
      end
      scaled = scaled / den;
      r.mag = scaled[31:0];
      return r;
    endfunction

    function void note(logic [31:0] f);
      expected_q.push_back(magnitude(f));
    endfunction

    function void check(logic [31:0] mag, logic sat, logic zden);
      mag_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word mag=%h sat=%b zden=%b", $time, mag, sat, zden);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (e.sat) n_sat++;
      if (e.zden) n_zden++;
      if (e.mag !== mag) begin
        $display("%0t: mag_squared expected %h got %h", $time, e.mag, mag);
        errors++;
      end
      if (e.sat !== sat) begin
        $display("%0t: saturated expected %b got %b", $time, e.sat, sat);
        errors++;
      end
      if (e.zden !== zden) begin
        $display("%0t: zero_denominator expected %b got %b", $time, e.zden, zden);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] freq_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] mag_squared_o;
  logic        saturated_o;
  logic        zero_denominator_o;

  mag_scoreboard sb = new();
  bit            no_idle;
  int unsigned   cycles;
  int unsigned   sent;

  biquad_analog_magnitude_squared_unit u_top (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note(freq_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check(mag_squared_o, saturated_o, zero_denominator_o);
  end

  // result side: random stall before each word
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic cfg_write(bams_pkg::reg_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, d);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic setup(logic [2:0] t, logic [31:0] c, logic [31:0] q, logic [31:0] g);
    drain();
    cfg_write(bams_pkg::REG_TYPE, ($urandom & ~32'd7) | 32'(t));
    cfg_write(bams_pkg::REG_CENTER, c);
    cfg_write(bams_pkg::REG_QUALITY, q);
    cfg_write(bams_pkg::REG_GAIN, g);
  endtask

  task automatic send_freq(logic [31:0] f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    freq_i     <= f;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [31:0] pick_word(logic [31:0] anchor);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return anchor + $urandom_range(0, 512) - 32'd256;
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_nonzero();
    logic [31:0] v;
    v = pick_word(32'h0100_0000);
    return (v == 0 && $urandom_range(0, 3) != 0) ? 32'd1 : v;
  endfunction

  initial begin
    logic [31:0] d_freq[3];
    logic [2:0]  t;
    sb.set_reg(bams_pkg::REG_TYPE, 32'd0);
    sb.set_reg(bams_pkg::REG_CENTER, 32'h1000_0000);
    sb.set_reg(bams_pkg::REG_QUALITY, 32'd11863283);
    sb.set_reg(bams_pkg::REG_GAIN, 32'h0100_0000);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    d_freq = '{32'd0, 32'h1000_0000, 32'hFFFF_FFFF};
    foreach (d_freq[i]) send_freq(d_freq[i]);
    for (int ft = 0; ft < 8; ft++) begin
      setup(ft[2:0], (ft % 2) ? 32'd0 : 32'hFFFF_FFFF, (ft == 3) ? 32'd0 : 32'hFFFF_FFFF,
            (ft == 4) ? 32'd0 : 32'h0400_0000);
      foreach (d_freq[i]) send_freq(d_freq[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      logic [31:0] c;
      t = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      c = pick_word(32'h1000_0000);
      setup(t, c, pick_nonzero(), pick_nonzero());
      no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < PER_PHASE; i++) send_freq(pick_word(c));
      no_idle = 0;
    end

    drain();
    repeat (80) @(posedge clk_i);
    $display("frequencies sent: %0d, results checked: %0d (saturated %0d, zero denominator %0d)",
             sent, sb.checked, sb.n_sat, sb.n_zden);
    $display("covered all eight filter type codes and %0d register settings", PHASES + 9);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
